>>> rtl/kalman_position_velocity_filter_assert.svh
// Assertion macros for the position/velocity filter.
// Used by kpvf_ctrl; expects clk and rst_n in scope.
`ifndef KALMAN_POSITION_VELOCITY_FILTER_ASSERT_SVH
`define KALMAN_POSITION_VELOCITY_FILTER_ASSERT_SVH
`ifndef ASSERT_OFF
`define KPVF_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define KPVF_ASSERT_NEVER(lbl, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define KPVF_ASSERT(lbl, prop, msg)
`define KPVF_ASSERT_NEVER(lbl, expr, msg)
`endif
`endif

>>> rtl/kpvf_pkg.sv
// Shared types, constants and the step program of the filter sequencer.
// No dependencies.
package kpvf_pkg;

    localparam int IO_W       = 32;
    localparam int DT_W       = 16;
    localparam int IO_FRAC    = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 24;
    localparam int STEP_W     = 5;

    localparam logic [CFG_IDX_W-1:0] CFG_QD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_QV = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RN = 2'd2;

    localparam logic [CFG_DATA_W-1:0] QD_RESET = 24'd262;
    localparam logic [CFG_DATA_W-1:0] QV_RESET = 24'd5243;
    localparam logic [CFG_DATA_W-1:0] RN_RESET = 24'd983040;

    localparam logic [STEP_W-1:0] LAST_STEP = 5'd27;

    typedef enum logic [1:0] {OP_ADD, OP_SUB, OP_MUL, OP_DIV} alu_op_t;

    typedef enum logic [4:0] {
        R_DS, R_VS, R_P00, R_P01, R_P10, R_P11,
        R_MEAS, R_DT, R_QD, R_QV, R_RN,
        R_DP, R_T, R_Y, R_S, R_K0, R_K1,
        R_N00, R_N01, R_N10, R_N11, R_TMP
    } reg_sel_t;

    typedef struct packed {
        alu_op_t  op;
        reg_sel_t a;
        reg_sel_t b;
        reg_sel_t d;
    } uop_t;

    typedef struct packed {
        logic load;
        logic start;
        uop_t uop;
    } kpvf_cmd_t;

    typedef struct packed {
        logic done;
    } kpvf_status_t;

    typedef enum logic [1:0] {ST_IDLE, ST_ISSUE, ST_WAIT, ST_OUT} ctrl_state_t;
    typedef enum logic [1:0] {EX_IDLE, EX_MUL, EX_DIV, EX_FIN} exec_state_t;

    function automatic uop_t mk(input alu_op_t op, input reg_sel_t d,
                                input reg_sel_t a, input reg_sel_t b);
        uop_t u;
        u.op = op;
        u.a  = a;
        u.b  = b;
        u.d  = d;
        return u;
    endfunction

    // One filter update: predict, gains, correct, covariance update
    function automatic uop_t prog_step(input logic [STEP_W-1:0] step);
        uop_t u;
        case (step)
            5'd0:    u = mk(OP_MUL, R_TMP, R_DT,   R_VS);
            5'd1:    u = mk(OP_ADD, R_DP,  R_DS,   R_TMP);
            5'd2:    u = mk(OP_ADD, R_T,   R_P10,  R_P01);
            5'd3:    u = mk(OP_MUL, R_TMP, R_P11,  R_DT);
            5'd4:    u = mk(OP_ADD, R_T,   R_T,    R_TMP);
            5'd5:    u = mk(OP_MUL, R_TMP, R_DT,   R_T);
            5'd6:    u = mk(OP_ADD, R_N00, R_P00,  R_TMP);
            5'd7:    u = mk(OP_ADD, R_N00, R_N00,  R_QD);
            5'd8:    u = mk(OP_MUL, R_TMP, R_DT,   R_P11);
            5'd9:    u = mk(OP_ADD, R_N01, R_P01,  R_TMP);
            5'd10:   u = mk(OP_ADD, R_N10, R_P10,  R_TMP);
            5'd11:   u = mk(OP_ADD, R_N11, R_P11,  R_QV);
            5'd12:   u = mk(OP_SUB, R_Y,   R_MEAS, R_DP);
            5'd13:   u = mk(OP_ADD, R_S,   R_N00,  R_RN);
            5'd14:   u = mk(OP_DIV, R_K0,  R_N00,  R_S);
            5'd15:   u = mk(OP_DIV, R_K1,  R_N10,  R_S);
            5'd16:   u = mk(OP_MUL, R_TMP, R_K0,   R_Y);
            5'd17:   u = mk(OP_ADD, R_DS,  R_DP,   R_TMP);
            5'd18:   u = mk(OP_MUL, R_TMP, R_K1,   R_Y);
            5'd19:   u = mk(OP_ADD, R_VS,  R_VS,   R_TMP);
            5'd20:   u = mk(OP_MUL, R_TMP, R_K0,   R_N00);
            5'd21:   u = mk(OP_SUB, R_P00, R_N00,  R_TMP);
            5'd22:   u = mk(OP_MUL, R_TMP, R_K0,   R_N01);
            5'd23:   u = mk(OP_SUB, R_P01, R_N01,  R_TMP);
            5'd24:   u = mk(OP_MUL, R_TMP, R_K1,   R_N00);
            5'd25:   u = mk(OP_SUB, R_P10, R_N10,  R_TMP);
            5'd26:   u = mk(OP_MUL, R_TMP, R_K1,   R_N01);
            5'd27:   u = mk(OP_SUB, R_P11, R_N11,  R_TMP);
            default: u = mk(OP_ADD, R_TMP, R_TMP,  R_TMP);
        endcase
        return u;
    endfunction

endpackage

>>> rtl/kpvf_datapath.sv
// Filter datapath: register set, saturating add/sub, 8-bit-per-cycle multiplier,
// restoring divider, format conversion and configuration registers. Uses kpvf_pkg.
module kpvf_datapath
    import kpvf_pkg::*;
#(
    parameter int DATA_WIDTH = 32,
    parameter int FRAC_BITS  = 16
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  kpvf_cmd_t             cmd,
    output kpvf_status_t          status,
    input  logic [IO_W+DT_W-1:0]  in_data,
    input  logic                  cfg_wr,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output logic [2*IO_W-1:0]     out_data
);

    localparam int W   = DATA_WIDTH;
    localparam int F   = FRAC_BITS;
    localparam int NCH = (W + 7) / 8;
    localparam int MW  = NCH * 8;
    localparam int PW  = MW + W;
    localparam int DW  = W + F;
    localparam int CW  = $clog2(DW + 1);
    localparam int KL  = (F > IO_FRAC) ? F - IO_FRAC : 0;
    localparam int KR  = (F < IO_FRAC) ? IO_FRAC - F : 0;

    localparam logic signed [63:0] MAXW = (64'sd1 <<< (W - 1)) - 64'sd1;
    localparam logic signed [63:0] MINW = -MAXW - 64'sd1;
    localparam logic signed [63:0] MAXO = 64'sd2147483647;
    localparam logic signed [63:0] MINO = -MAXO - 64'sd1;
    localparam logic [PW:0]        HALF = (PW + 1)'(1) << (F - 1);
    localparam logic [CW-1:0]      MUL_LAST = CW'(NCH - 1);
    localparam logic [CW-1:0]      DIV_LAST = CW'(DW - 1);

    typedef logic signed [W-1:0] word_t;

    word_t ds_reg, vs_reg, p00_reg, p01_reg, p10_reg, p11_reg;
    word_t meas_reg, dt_reg, qd_reg, qv_reg, rn_reg;
    word_t dp_reg, t_reg, y_reg, s_reg, k0_reg, k1_reg;
    word_t n00_reg, n01_reg, n10_reg, n11_reg, tmp_reg;
    logic [CFG_DATA_W-1:0] cqd_reg, cqv_reg, crn_reg;

    exec_state_t   exec_reg, exec_next;
    logic          done_reg, done_next;
    logic [CW-1:0] cnt_reg, cnt_next;

    reg_sel_t      dst_reg;
    logic          neg_reg;
    logic          dz_reg;
    logic          isdiv_reg;
    logic [W-1:0]  ma_reg;
    logic [MW-1:0] mbr_reg;
    logic [PW-1:0] acc_reg;
    logic [DW-1:0] dv_reg;
    logic [DW-1:0] q_reg;
    logic [W-1:0]  rem_reg;

    word_t        opa, opb, add_res, sub_res, mul_res, div_res, wr_val;
    logic         wr_en;
    reg_sel_t     wr_sel;
    logic [W:0]   sum_w, dif_w;
    logic [W-1:0] ma_c, mb_c, lim;
    logic [W+7:0] pp;
    logic [PW-1:0] acc_next;
    logic [PW:0]  rnd_q;
    logic [W-1:0] mq, dq;
    logic [W:0]   rem_sh;
    logic         ge;

    function automatic word_t sat_w(input logic signed [63:0] v);
        if (v > MAXW)
            return MAXW[W-1:0];
        else if (v < MINW)
            return MINW[W-1:0];
        return v[W-1:0];
    endfunction

    function automatic word_t conv_in(input logic signed [63:0] v);
        logic signed [63:0] x;
        x = (v <<< KL) >>> KR;
        return sat_w(x);
    endfunction

    function automatic logic [IO_W-1:0] conv_out(input word_t v);
        logic signed [63:0] x;
        x = 64'(v);
        x = (x <<< KR) >>> KL;
        if (x > MAXO)
            return MAXO[IO_W-1:0];
        else if (x < MINO)
            return MINO[IO_W-1:0];
        return x[IO_W-1:0];
    endfunction

    function automatic word_t rf_read(input reg_sel_t s);
        case (s)
            R_DS:    return ds_reg;
            R_VS:    return vs_reg;
            R_P00:   return p00_reg;
            R_P01:   return p01_reg;
            R_P10:   return p10_reg;
            R_P11:   return p11_reg;
            R_MEAS:  return meas_reg;
            R_DT:    return dt_reg;
            R_QD:    return qd_reg;
            R_QV:    return qv_reg;
            R_RN:    return rn_reg;
            R_DP:    return dp_reg;
            R_T:     return t_reg;
            R_Y:     return y_reg;
            R_S:     return s_reg;
            R_K0:    return k0_reg;
            R_K1:    return k1_reg;
            R_N00:   return n00_reg;
            R_N01:   return n01_reg;
            R_N10:   return n10_reg;
            R_N11:   return n11_reg;
            R_TMP:   return tmp_reg;
            default: return '0;
        endcase
    endfunction

    always_comb
    begin
        opa = rf_read(cmd.uop.a);
        opb = rf_read(cmd.uop.b);
    end

    // saturating add/sub: overflow when the two top bits of the W+1 result differ
    always_comb
    begin
        sum_w = {opa[W-1], opa} + {opb[W-1], opb};
        dif_w = {opa[W-1], opa} - {opb[W-1], opb};
        if (sum_w[W] != sum_w[W-1])
            add_res = sum_w[W] ? MINW[W-1:0] : MAXW[W-1:0];
        else
            add_res = sum_w[W-1:0];
        if (dif_w[W] != dif_w[W-1])
            sub_res = dif_w[W] ? MINW[W-1:0] : MAXW[W-1:0];
        else
            sub_res = dif_w[W-1:0];
    end

    assign ma_c = opa[W-1] ? W'(-opa) : W'(opa);
    assign mb_c = opb[W-1] ? W'(-opb) : W'(opb);
    assign lim  = neg_reg ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};

    // multiplier: MSB chunk first, magnitude product then round half away
    always_comb
    begin
        pp       = ma_reg * mbr_reg[MW-1 -: 8];
        acc_next = (acc_reg << 8) + PW'(pp);
        rnd_q    = ((PW + 1)'(acc_reg) + HALF) >> F;
        mq       = (rnd_q > (PW + 1)'(lim)) ? lim : rnd_q[W-1:0];
        mul_res  = neg_reg ? W'(-mq) : mq;
    end

    always_comb
    begin
        rem_sh  = {rem_reg, dv_reg[DW-1]};
        ge      = rem_sh >= {1'b0, mbr_reg[W-1:0]};
        dq      = (q_reg > DW'(lim)) ? lim : q_reg[W-1:0];
        div_res = dz_reg ? '0 : (neg_reg ? W'(-dq) : dq);
    end

    always_comb
    begin
        exec_next = exec_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        wr_en     = 1'b0;
        wr_sel    = cmd.uop.d;
        wr_val    = add_res;
        case (exec_reg)
            EX_IDLE:
            begin
                if (cmd.start)
                begin
                    cnt_next = '0;
                    case (cmd.uop.op)
                        OP_ADD:
                        begin
                            wr_en     = 1'b1;
                            done_next = 1'b1;
                        end
                        OP_SUB:
                        begin
                            wr_en     = 1'b1;
                            wr_val    = sub_res;
                            done_next = 1'b1;
                        end
                        OP_MUL:  exec_next = EX_MUL;
                        OP_DIV:  exec_next = EX_DIV;
                        default: exec_next = EX_IDLE;
                    endcase
                end
            end
            EX_MUL:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == MUL_LAST)
                    exec_next = EX_FIN;
            end
            EX_DIV:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == DIV_LAST)
                    exec_next = EX_FIN;
            end
            EX_FIN:
            begin
                wr_en     = 1'b1;
                wr_sel    = dst_reg;
                wr_val    = isdiv_reg ? div_res : mul_res;
                done_next = 1'b1;
                exec_next = EX_IDLE;
            end
            default: exec_next = EX_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            exec_reg <= EX_IDLE;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            exec_reg <= exec_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    assign status.done = done_reg;

    // multi-cycle operand and iteration registers
    always_ff @(posedge clk)
    begin
        if (cmd.start && exec_reg == EX_IDLE)
        begin
            dst_reg   <= cmd.uop.d;
            neg_reg   <= opa[W-1] ^ opb[W-1];
            dz_reg    <= (opb == '0);
            isdiv_reg <= (cmd.uop.op == OP_DIV);
            ma_reg    <= ma_c;
            mbr_reg   <= MW'(mb_c);
            acc_reg   <= '0;
            dv_reg    <= {ma_c, {F{1'b0}}};
            q_reg     <= '0;
            rem_reg   <= '0;
        end
        else if (exec_reg == EX_MUL)
        begin
            acc_reg <= acc_next;
            mbr_reg <= mbr_reg << 8;
        end
        else if (exec_reg == EX_DIV)
        begin
            rem_reg <= ge ? W'(rem_sh - {1'b0, mbr_reg[W-1:0]}) : rem_sh[W-1:0];
            q_reg   <= {q_reg[DW-2:0], ge};
            dv_reg  <= dv_reg << 1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cqd_reg <= QD_RESET;
            cqv_reg <= QV_RESET;
            crn_reg <= RN_RESET;
        end
        else if (cfg_wr)
        begin
            case (cfg_index)
                CFG_QD:  cqd_reg <= cfg_data;
                CFG_QV:  cqv_reg <= cfg_data;
                CFG_RN:  crn_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ds_reg <= '0; vs_reg <= '0;
            p00_reg <= '0; p01_reg <= '0; p10_reg <= '0; p11_reg <= '0;
            meas_reg <= '0; dt_reg <= '0; qd_reg <= '0; qv_reg <= '0; rn_reg <= '0;
            dp_reg <= '0; t_reg <= '0; y_reg <= '0; s_reg <= '0;
            k0_reg <= '0; k1_reg <= '0;
            n00_reg <= '0; n01_reg <= '0; n10_reg <= '0; n11_reg <= '0;
            tmp_reg <= '0;
        end
        else if (cmd.load)
        begin
            meas_reg <= conv_in({{(64-IO_W){in_data[IO_W-1]}}, in_data[IO_W-1:0]});
            dt_reg   <= conv_in({{(64-DT_W){1'b0}}, in_data[IO_W+DT_W-1:IO_W]});
            qd_reg   <= conv_in({{(64-CFG_DATA_W){1'b0}}, cqd_reg});
            qv_reg   <= conv_in({{(64-CFG_DATA_W){1'b0}}, cqv_reg});
            rn_reg   <= conv_in({{(64-CFG_DATA_W){1'b0}}, crn_reg});
        end
        else if (wr_en)
        begin
            case (wr_sel)
                R_DS:    ds_reg   <= wr_val;
                R_VS:    vs_reg   <= wr_val;
                R_P00:   p00_reg  <= wr_val;
                R_P01:   p01_reg  <= wr_val;
                R_P10:   p10_reg  <= wr_val;
                R_P11:   p11_reg  <= wr_val;
                R_MEAS:  meas_reg <= wr_val;
                R_DT:    dt_reg   <= wr_val;
                R_QD:    qd_reg   <= wr_val;
                R_QV:    qv_reg   <= wr_val;
                R_RN:    rn_reg   <= wr_val;
                R_DP:    dp_reg   <= wr_val;
                R_T:     t_reg    <= wr_val;
                R_Y:     y_reg    <= wr_val;
                R_S:     s_reg    <= wr_val;
                R_K0:    k0_reg   <= wr_val;
                R_K1:    k1_reg   <= wr_val;
                R_N00:   n00_reg  <= wr_val;
                R_N01:   n01_reg  <= wr_val;
                R_N10:   n10_reg  <= wr_val;
                R_N11:   n11_reg  <= wr_val;
                R_TMP:   tmp_reg  <= wr_val;
                default: ;
            endcase
        end
    end

    assign out_data = {conv_out(vs_reg), conv_out(ds_reg)};

endmodule

>>> rtl/kpvf_ctrl.sv
// Sequencer for the filter: input handshake, step program issue, result handshake.
// Uses kpvf_pkg and the assertion macros header.
`include "kalman_position_velocity_filter_assert.svh"
module kpvf_ctrl
    import kpvf_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    output logic         m_tvalid,
    input  logic         m_tready,
    output kpvf_cmd_t    cmd,
    input  kpvf_status_t status
);

    ctrl_state_t       state_reg, state_next;
    logic [STEP_W-1:0] step_reg, step_next;

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        case (state_reg)
            ST_IDLE:
            begin
                step_next = '0;
                if (s_tvalid)
                    state_next = ST_ISSUE;
            end
            ST_ISSUE: state_next = ST_WAIT;
            ST_WAIT:
            begin
                if (status.done)
                begin
                    if (step_reg == LAST_STEP)
                        state_next = ST_OUT;
                    else
                    begin
                        step_next  = step_reg + 1'b1;
                        state_next = ST_ISSUE;
                    end
                end
            end
            ST_OUT:
            begin
                if (m_tready)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        s_tready  = 1'b0;
        m_tvalid  = 1'b0;
        cmd.load  = 1'b0;
        cmd.start = 1'b0;
        cmd.uop   = prog_step(step_reg);
        case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                cmd.load = s_tvalid;
            end
            ST_ISSUE: cmd.start = 1'b1;
            ST_WAIT:  cmd.start = 1'b0;
            ST_OUT:   m_tvalid  = 1'b1;
            default:  cmd.start = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    `KPVF_ASSERT(a_start_single, cmd.start |=> !cmd.start, "start held two cycles")
    `KPVF_ASSERT(a_done_in_wait, status.done |-> state_reg == ST_WAIT, "done outside wait")
    `KPVF_ASSERT_NEVER(a_step_range, step_reg > LAST_STEP, "step past program end")
    `KPVF_ASSERT_NEVER(a_both_sides, s_tready && m_tvalid, "input and result open together")

endmodule

>>> rtl/kalman_position_velocity_filter.sv
// Two-state (distance, velocity) Kalman filter, top level.
// Joins kpvf_ctrl and kpvf_datapath; uses kpvf_pkg.
//
// Usage:
//   s_* channel: one measurement item per handshake.
//   m_* channel: one result item (distance and velocity estimate) per input item.
//   cfg_*: register writes (0 distance noise, 1 velocity noise, 2 measurement
//   noise, unsigned Q8.16); always ready, write only while the filter is idle.
// Flow: one item at a time. An item runs 16 add/sub steps, 10 multiplies
//   and 2 divides in turn, then m_tvalid rises. The 1-bit-per-cycle divider
//   (DATA_WIDTH + FRAC_BITS quotient bits) and the 8-bit-per-cycle
//   multiplier (ceil(DATA_WIDTH/8) chunks) take most of that time.
//   s_tready rises again once the result is taken.
// Reset: state and covariance clear to zero, noise registers take their
//   defaults; the filter is ready for an item right after reset.
// Stall: the result is held on m_tdata with m_tvalid high until m_tready;
//   no new item is taken meanwhile.
module kalman_position_velocity_filter
    import kpvf_pkg::*;
#(
    parameter int DATA_WIDTH = 32,
    parameter int FRAC_BITS  = 16
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [47:0]           s_tdata,   // measured_distance[31:0], time_step[47:32]
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [63:0]           m_tdata,   // distance_estimate[31:0], velocity_estimate[63:32]
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    kpvf_cmd_t    cmd;
    kpvf_status_t status;

    assign cfg_ready = 1'b1;

    kpvf_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd),
        .status   (status)
    );

    kpvf_datapath #(
        .DATA_WIDTH (DATA_WIDTH),
        .FRAC_BITS  (FRAC_BITS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .in_data   (s_tdata),
        .cfg_wr    (cfg_valid & cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .out_data  (m_tdata)
    );

endmodule
